// ----- rtl/core/rse_pkg.sv -----
package rse_pkg;

    localparam int MESSAGE_BYTES = 96;
    localparam int PARITY_BYTES  = 16;
    localparam int CountW        = $clog2(MESSAGE_BYTES + 1);
    localparam int DrainW        = $clog2(PARITY_BYTES);

    localparam logic [8:0] FIELD_POLY = 9'h11D;

    typedef logic [7:0]                    t_byte;
    typedef logic [PARITY_BYTES:0][7:0]    t_gen;
    typedef logic [PARITY_BYTES-1:0][7:0]  t_parity;

    typedef struct packed {
        t_byte code_byte;
        logic  is_parity;
        logic  last;
    } t_code;

    // multiply in gf(256) modulo the field polynomial
    function automatic t_byte gf_mul(input t_byte a, input t_byte b);
        logic [8:0] x;
        t_byte      acc;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // product of (x + alpha^r) over r = 0 .. PARITY_BYTES-1
    function automatic t_gen build_gen();
        t_gen  g;
        t_byte root;
        g    = '0;
        g[0] = 8'd1;
        root = 8'd1;
        for (int r = 0; r < PARITY_BYTES; r++) begin
            for (int k = r + 1; k > 0; k--) begin
                g[k] = g[k-1] ^ gf_mul(g[k], root);
            end
            g[0] = gf_mul(g[0], root);
            root = gf_mul(root, 8'd2);
        end
        return g;
    endfunction

    localparam t_gen GEN_POLY = build_gen();

endpackage

// ----- rtl/core/reed_solomon_encoder.sv -----
// Systematic RS(112,96) encoder over GF(256).
// Input channel: i_message_byte with i_valid / o_ready, one message byte per
// transaction. Output channel: o_code_byte, o_is_parity, o_last with
// o_valid / i_ready, one codeword symbol per transaction.
// Each message byte is passed through into the output register, or into the
// skid stage while the output stalls; a byte can be taken in every cycle
// in which o_ready is high. After the 96th byte of a codeword the 16 parity
// bytes follow, highest register first, from the parity shift register, one
// per cycle while the skid stage is empty; o_last marks the final one.
// o_ready is low while parity drains, so input and drain never overlap.
// Output is a register plus a skid stage, so o_ready never depends on
// i_ready in the same cycle; when the receiver stalls, one more symbol is
// held in the skid stage and then input and drain stop until it moves.
// Reset (synchronous, active low) clears the parity registers, the byte
// counter, the drain state and both output stages; no clearing pass.
module reed_solomon_encoder
    import rse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_message_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_code_byte,
    output logic       o_is_parity,
    output logic       o_last
);

    t_parity           r_parity, n_parity, lfsr_next, shift_next;
    logic [CountW-1:0] r_count, n_count;
    logic [DrainW-1:0] r_drain_cnt, n_drain_cnt;
    logic              r_drain, n_drain;
    t_code             r_out, n_out, r_skid, n_skid, prod_item;
    logic              r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    logic              in_fire, drain_fire, prod_valid, take, out_load;
    logic              msg_last, drain_last;
    t_byte             fb;

    assign o_ready    = !r_skid_valid && !r_drain;
    assign in_fire    = i_valid && o_ready;
    assign drain_fire = r_drain && !r_skid_valid;
    assign msg_last   = (r_count == CountW'(MESSAGE_BYTES - 1));
    assign drain_last = (r_drain_cnt == DrainW'(PARITY_BYTES - 1));
    assign fb         = i_message_byte ^ r_parity[PARITY_BYTES-1];

    // parity lfsr update and plain shift for draining
    always_comb begin
        lfsr_next[0]  = gf_mul(GEN_POLY[0], fb);
        shift_next[0] = '0;
        for (int j = 1; j < PARITY_BYTES; j++) begin
            lfsr_next[j]  = r_parity[j-1] ^ gf_mul(GEN_POLY[j], fb);
            shift_next[j] = r_parity[j-1];
        end
    end

    always_comb begin
        n_parity    = r_parity;
        n_count     = r_count;
        n_drain     = r_drain;
        n_drain_cnt = r_drain_cnt;
        if (in_fire) begin
            n_parity = lfsr_next;
            if (msg_last) begin
                n_count     = '0;
                n_drain     = 1'b1;
                n_drain_cnt = '0;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (drain_fire) begin
            n_parity    = shift_next;
            n_drain_cnt = r_drain_cnt + 1'b1;
            if (drain_last) begin
                n_drain = 1'b0;
            end
        end
    end

    // symbol produced this cycle
    always_comb begin
        prod_valid = in_fire || drain_fire;
        if (in_fire) begin
            prod_item = '{code_byte: i_message_byte, is_parity: 1'b0, last: 1'b0};
        end else begin
            prod_item = '{code_byte: r_parity[PARITY_BYTES-1], is_parity: 1'b1,
                          last: drain_last};
        end
    end

    // output register and skid stage
    assign take     = r_out_valid && i_ready;
    assign out_load = take || !r_out_valid;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (out_load) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = prod_item;
                n_out_valid = prod_valid;
            end
        end else if (prod_valid) begin
            n_skid       = prod_item;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity     <= '0;
            r_count      <= '0;
            r_drain      <= 1'b0;
            r_drain_cnt  <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_parity     <= n_parity;
            r_count      <= n_count;
            r_drain      <= n_drain;
            r_drain_cnt  <= n_drain_cnt;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid     = r_out_valid;
    assign o_code_byte = r_out.code_byte;
    assign o_is_parity = r_out.is_parity;
    assign o_last      = r_out.last;

endmodule

// ----- rtl/core/rse_checker.sv -----
module rse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_message_byte,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_code_byte,
    input logic       o_is_parity,
    input logic       o_last
);

    // last flag only on parity symbols
    a_last_is_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_last || o_is_parity))
        else $error("last flag on a non-parity symbol");

    // parity symbols follow back to back until the last one
    a_parity_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_parity && !o_last && i_ready) |=> (o_valid && o_is_parity))
        else $error("parity run broken before last symbol");

    // output empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_code_byte) && $stable(o_is_parity) && $stable(o_last)))
        else $error("stalled output transaction changed");

    // message byte passes straight through when the output moves on
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (!o_valid || i_ready)) |=>
            (o_valid && !o_is_parity && (o_code_byte == $past(i_message_byte))))
        else $error("message byte not passed through");

endmodule

bind reed_solomon_encoder rse_checker u_rse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_message_byte (i_message_byte),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_code_byte    (o_code_byte),
    .o_is_parity    (o_is_parity),
    .o_last         (o_last)
);
